>>> rtl/core/gcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gait command sequencer package
// Command and action codes, result beat and per-tick bundle types.
// ----------------------------------------------------------------------------
package gcs_pkg;

  typedef logic [3:0] cmd_t;
  typedef logic [3:0] act_t;
  typedef logic [2:0] stage_t;
  typedef logic [1:0] cnt_t;

  localparam cmd_t CMD_NONE       = 4'd0;
  localparam cmd_t CMD_STOP       = 4'd1;
  localparam cmd_t CMD_CONNECT    = 4'd2;
  localparam cmd_t CMD_DISCONNECT = 4'd3;
  localparam cmd_t CMD_FWD        = 4'd4;
  localparam cmd_t CMD_BACK       = 4'd5;
  localparam cmd_t CMD_ROTL       = 4'd6;
  localparam cmd_t CMD_ROTR       = 4'd7;
  localparam cmd_t CMD_FWDL       = 4'd8;
  localparam cmd_t CMD_FWDR       = 4'd9;
  localparam cmd_t CMD_BWDL       = 4'd10;
  localparam cmd_t CMD_BWDR       = 4'd11;
  localparam cmd_t CMD_OTHER      = 4'd12;

  localparam act_t ACT_SWITCH = 4'd0;
  localparam act_t ACT_STAND  = 4'd1;
  localparam act_t ACT_SIT    = 4'd2;
  localparam act_t ACT_EVEN   = 4'd11;
  localparam act_t ACT_ODD    = 4'd12;

  localparam stage_t STAGE_EVEN  = 3'd0;
  localparam stage_t STAGE_ODD   = 3'd1;
  localparam stage_t STAGE_MOVE0 = 3'd2;
  localparam stage_t STAGE_MOVE1 = 3'd3;

  localparam int MaxBeats = 3;

  // One result beat.
  typedef struct packed {
    act_t action;
    logic last_action;
    logic in_transition;
    logic is_standing;
  } res_t;

  // All beats caused by one tick.
  typedef struct packed {
    cnt_t                  cnt;
    res_t [MaxBeats-1:0]   item;
  } bundle_t;

endpackage

>>> rtl/core/gcs_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gait command sequencer step
// Holds the sequencer state and works out the beats of one tick.
// ----------------------------------------------------------------------------
module gcs_step (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  gcs_pkg::cmd_t    cmd,
  input  logic             settled,
  output gcs_pkg::bundle_t bundle
);
  import gcs_pkg::*;

  typedef struct packed {
    logic has;
    act_t act;
    logic st_chg;
    logic st_val;
  } move_t;

  function automatic move_t move_lookup(input cmd_t c);
    move_t m;
    m = '0;
    if (c == CMD_CONNECT) begin
      m.has = 1'b1; m.act = ACT_STAND; m.st_chg = 1'b1; m.st_val = 1'b1;
    end else if (c == CMD_DISCONNECT) begin
      m.has = 1'b1; m.act = ACT_SIT; m.st_chg = 1'b1; m.st_val = 1'b0;
    end else if (c >= CMD_FWD && c <= CMD_BWDR) begin
      m.has = 1'b1; m.act = c - 4'd1;
    end
    return m;
  endfunction

  function automatic logic opposite(input cmd_t a, input cmd_t b);
    return (a == CMD_FWD  && b == CMD_BACK) || (a == CMD_BACK && b == CMD_FWD)  ||
           (a == CMD_ROTL && b == CMD_ROTR) || (a == CMD_ROTR && b == CMD_ROTL) ||
           (a == CMD_FWDR && b == CMD_BWDL) || (a == CMD_BWDL && b == CMD_FWDR) ||
           (a == CMD_FWDL && b == CMD_BWDR) || (a == CMD_BWDR && b == CMD_FWDL);
  endfunction

  cmd_t   prev_r, prev_nxt;
  logic   tm_r, tm_nxt;
  stage_t stage_r, stage_nxt;
  logic   st_r, st_nxt;

  cmd_t                cmd_c;
  cnt_t                n_v;
  res_t [MaxBeats-1:0] items_v;
  move_t               mv;
  logic                check;
  logic                start;

  always_comb begin
    cmd_c     = (cmd > CMD_OTHER) ? CMD_OTHER : cmd;
    prev_nxt  = prev_r;
    tm_nxt    = tm_r;
    stage_nxt = stage_r;
    st_nxt    = st_r;
    n_v       = '0;
    items_v   = '0;
    mv        = '0;
    check     = 1'b0;
    start     = 1'b0;
    if (settled) begin
      if (tm_r) begin
        case (stage_r) inside
          STAGE_EVEN: begin
            items_v[n_v] = {ACT_EVEN, 1'b0, tm_nxt, st_nxt};
            n_v = n_v + 2'd1;
          end
          STAGE_ODD: begin
            items_v[n_v] = {ACT_ODD, 1'b0, tm_nxt, st_nxt};
            n_v = n_v + 2'd1;
          end
          STAGE_MOVE0, STAGE_MOVE1: begin
            mv = move_lookup(prev_r);
            if (mv.has) begin
              if (mv.st_chg) st_nxt = mv.st_val;
              items_v[n_v] = {mv.act, 1'b0, tm_nxt, st_nxt};
              n_v = n_v + 2'd1;
            end
          end
          default: begin
            tm_nxt = 1'b0;
            items_v[n_v] = {ACT_SWITCH, 1'b0, tm_nxt, st_nxt};
            n_v = n_v + 2'd1;
          end
        endcase
        stage_nxt = stage_r + 3'd1;
      end else if (cmd_c != CMD_NONE && cmd_c != CMD_STOP) begin
        check = cmd_c != CMD_CONNECT && cmd_c != CMD_DISCONNECT &&
                prev_r != CMD_CONNECT && prev_r != CMD_DISCONNECT;
        if (check && cmd_c != prev_r) begin
          if (opposite(prev_r, cmd_c)) begin
            items_v[n_v] = {ACT_SWITCH, 1'b0, tm_nxt, st_nxt};
            n_v = n_v + 2'd1;
          end else begin
            // enter transition, this tick gives nothing
            start     = 1'b1;
            tm_nxt    = 1'b1;
            stage_nxt = '0;
          end
        end
        if (!start) begin
          mv = move_lookup(cmd_c);
          if (mv.has) begin
            if (mv.st_chg) st_nxt = mv.st_val;
            items_v[n_v] = {mv.act, 1'b0, tm_nxt, st_nxt};
            n_v = n_v + 2'd1;
          end
          items_v[n_v] = {ACT_SWITCH, 1'b0, tm_nxt, st_nxt};
          n_v = n_v + 2'd1;
        end
        prev_nxt = cmd_c;
      end
    end
    if (n_v != '0) items_v[n_v - 2'd1].last_action = 1'b1;
    bundle.cnt  = n_v;
    bundle.item = items_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= CMD_NONE;
      tm_r    <= 1'b0;
      stage_r <= '0;
      st_r    <= 1'b0;
    end else if (adv) begin
      prev_r  <= prev_nxt;
      tm_r    <= tm_nxt;
      stage_r <= stage_nxt;
      st_r    <= st_nxt;
    end
  end

endmodule

>>> rtl/core/gcs_serializer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gait command sequencer serializer
// Registers one tick's bundle and hands its beats out one per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module gcs_serializer (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  gcs_pkg::bundle_t bundle,
  output logic             ready,
  output logic             out_valid,
  input  logic             out_stall,
  output gcs_pkg::res_t    beat
);
  import gcs_pkg::*;

  logic                b_valid_r, b_valid_nxt;
  cnt_t                b_idx_r, b_idx_nxt;
  res_t [MaxBeats-1:0] b_item_r;
  logic                fire;
  logic                fire_last;
  logic                take;

  assign beat      = b_item_r[b_idx_r];
  assign out_valid = b_valid_r;
  assign fire      = b_valid_r && !out_stall;
  assign fire_last = fire && beat.last_action;
  assign ready     = !b_valid_r || fire_last;
  assign take      = load && (bundle.cnt != '0);

  always_comb begin
    b_valid_nxt = b_valid_r;
    b_idx_nxt   = b_idx_r;
    if (take) begin
      b_valid_nxt = 1'b1;
      b_idx_nxt   = '0;
    end else if (fire_last) begin
      b_valid_nxt = 1'b0;
    end else if (fire) begin
      b_idx_nxt = b_idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      b_idx_r   <= '0;
    end else begin
      b_valid_r <= b_valid_nxt;
      b_idx_r   <= b_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) b_item_r <= bundle.item;
  end

endmodule

>>> rtl/core/gait_command_sequencer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gait command sequencer unit
// Turns update ticks (command, legs settled) into zero to three action beats.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------
//   in_     | input     | in_valid/in_stall  | in_command, in_legs_settled
//   out_    | output    | out_valid/out_stall| out_action, out_last_action,
//           |           |                    | out_in_transition, out_is_standing
//
// A tick is registered on accept, decoded against the sequencer state once
// the bundle register frees up, and its beats land in that output bundle
// register, from which the first beat shows. One beat leaves per cycle while
// out_stall is low; ticks with no beats update the state but never reach the
// output port. rst_n (synchronous) clears the state to seated,
// no command, no transition. out_stall holds the current beat and backs up
// into in_stall once the input register is full.
//
module gait_command_sequencer_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  gcs_pkg::cmd_t      in_command,
  input  logic               in_legs_settled,
  output logic               out_valid,
  input  logic               out_stall,
  output gcs_pkg::act_t      out_action,
  output logic               out_last_action,
  output logic               out_in_transition,
  output logic               out_is_standing
);
  import gcs_pkg::*;

  // Input register
  logic    a_valid_r;
  cmd_t    a_cmd_r;
  logic    a_settled_r;

  logic    ser_ready;
  logic    a_move;
  logic    in_fire;
  bundle_t bundle;
  res_t    beat;

  // Advance the held tick into the decoder when the bundle register frees up.
  assign a_move   = a_valid_r && ser_ready;
  // Stall only while a tick is held and cannot advance.
  assign in_stall = a_valid_r && !ser_ready;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_fire) begin
      a_valid_r <= 1'b1;
    end else if (a_move) begin
      a_valid_r <= 1'b0;
    end
  end

  // Payload: capture on accept, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_cmd_r     <= in_command;
      a_settled_r <= in_legs_settled;
    end
  end

  // Decode the tick and update the sequencer state as it advances.
  gcs_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (a_move),
    .cmd     (a_cmd_r),
    .settled (a_settled_r),
    .bundle  (bundle)
  );

  // Drain the tick's beats one per cycle while out_stall is low.
  gcs_serializer u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (a_move),
    .bundle    (bundle),
    .ready     (ser_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .beat      (beat)
  );

  assign out_action        = beat.action;
  assign out_last_action   = beat.last_action;
  assign out_in_transition = beat.in_transition;
  assign out_is_standing   = beat.is_standing;

endmodule
